@@ src/base64_stream_codec_top_assert.svh @@
// ---------------------------------------------------------------------------
// base64_stream_codec_top_assert.svh
// Assertion macros for the Base64 stream codec.
// ---------------------------------------------------------------------------
`ifndef BASE64_STREAM_CODEC_TOP_ASSERT_SVH
`define BASE64_STREAM_CODEC_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define B64SC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define B64SC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/b64sc_pkg.sv @@
// ---------------------------------------------------------------------------
// b64sc_pkg
// Shared types, constants and character helpers of the Base64 stream codec.
// ---------------------------------------------------------------------------
package b64sc_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam logic [15:0] COUNT_LIMIT = (COUNT_WIDTH >= 16) ? 16'hFFFF
                                        : 16'((64'd1 << COUNT_WIDTH) - 64'd1);

    localparam int ADDR_W = 3;
    localparam logic REG_DIRECTION = 1'b0;   // word index of the direction register

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] PAD_CHAR     = 8'h3D;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CLS_ALPHA   = 2'd0,
        CLS_STOP    = 2'd1,
        CLS_NEWLINE = 2'd2,
        CLS_BAD     = 2'd3
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [5:0]  sextet;
    } char_info_t;

    // Up to four result beats caused by one input item
    typedef struct packed {
        logic [2:0]       n;
        logic [3:0][7:0]  value;
        kind_t [3:0]      kind;
        logic             msg_end;
        logic [15:0]      count;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    function automatic logic [7:0] b64_char(input logic [5:0] s);
        logic [7:0] r;
        if (s < 6'd26) begin
            r = 8'd65 + {2'b00, s};
        end else if (s < 6'd52) begin
            r = 8'd71 + {2'b00, s};
        end else if (s < 6'd62) begin
            r = {2'b00, s} - 8'd4;
        end else if (s == 6'd62) begin
            r = 8'h2B;
        end else begin
            r = 8'h2F;
        end
        return r;
    endfunction

    function automatic char_info_t classify(input logic [7:0] c);
        char_info_t info;
        info.sextet = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            info.cls    = CLS_ALPHA;
            info.sextet = 6'(c - 8'd65);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            info.cls    = CLS_ALPHA;
            info.sextet = 6'(c - 8'd71);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            info.cls    = CLS_ALPHA;
            info.sextet = 6'(c + 8'd4);
        end else if (c == 8'h2B) begin
            info.cls    = CLS_ALPHA;
            info.sextet = 6'd62;
        end else if (c == 8'h2F) begin
            info.cls    = CLS_ALPHA;
            info.sextet = 6'd63;
        end else if (c == PAD_CHAR || c == 8'h00 || c[7]) begin
            info.cls = CLS_STOP;
        end else if (c == NEWLINE_CHAR) begin
            info.cls = CLS_NEWLINE;
        end else begin
            info.cls = CLS_BAD;
        end
        return info;
    endfunction

endpackage

@@ src/b64sc_front.sv @@
// ---------------------------------------------------------------------------
// b64sc_front
// Accepts input items, runs encoder/decoder state and builds result jobs.
// ---------------------------------------------------------------------------
module b64sc_front
    import b64sc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         direction,
    input  logic         in_valid,
    input  logic [7:0]   in_byte,
    input  logic         in_last,
    input  fifo_status_t fifo_status,
    output logic         in_stall,
    output logic         push,
    output job_t         job
);

    logic [3:0]  enc_leftover_reg, enc_leftover_next;
    logic [1:0]  enc_phase_reg, enc_phase_next;
    logic [7:0]  dec_partial_reg, dec_partial_next;
    logic [3:0]  dec_free_reg, dec_free_next;
    logic        dec_stopped_reg, dec_stopped_next;
    logic        dec_failed_reg, dec_failed_next;
    logic [15:0] dec_total_reg, dec_total_next;

    logic        accept;
    char_info_t  info;
    logic [3:0]  fb;
    logic [3:0]  sh;
    logic [3:0]  nf;
    logic [2:0]  dn;

    assign in_stall = fifo_status.full;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && (job.n != 3'd0);
    assign info     = classify(in_byte);

    always_comb
    begin
        job               = '0;
        enc_leftover_next = enc_leftover_reg;
        enc_phase_next    = enc_phase_reg;
        dec_partial_next  = dec_partial_reg;
        dec_free_next     = dec_free_reg;
        dec_stopped_next  = dec_stopped_reg;
        dec_failed_next   = dec_failed_reg;
        dec_total_next    = dec_total_reg;
        fb                = 4'd8;
        sh                = 4'd0;
        nf                = 4'd0;
        dn                = 3'd0;

        if (direction == DIR_ENCODE)
        begin
            case (enc_phase_reg)
                2'd0:
                begin
                    job.value[0]      = b64_char(in_byte[7:2]);
                    enc_leftover_next = {2'b00, in_byte[1:0]};
                    enc_phase_next    = 2'd1;
                    job.n             = 3'd1;
                end
                2'd1:
                begin
                    job.value[0]      = b64_char({enc_leftover_reg[1:0], in_byte[7:4]});
                    enc_leftover_next = in_byte[3:0];
                    enc_phase_next    = 2'd2;
                    job.n             = 3'd1;
                end
                default:
                begin
                    job.value[0]      = b64_char({enc_leftover_reg, in_byte[7:6]});
                    job.value[1]      = b64_char(in_byte[5:0]);
                    enc_leftover_next = 4'd0;
                    enc_phase_next    = 2'd0;
                    job.n             = 3'd2;
                end
            endcase
            if (in_last)
            begin
                // flush leftover bits and pad to a whole quartet
                if (enc_phase_next == 2'd1)
                begin
                    job.value[1] = b64_char({enc_leftover_next[1:0], 4'b0000});
                    job.value[2] = PAD_CHAR;
                    job.value[3] = PAD_CHAR;
                    job.n        = 3'd4;
                end
                else if (enc_phase_next == 2'd2)
                begin
                    job.value[1] = b64_char({enc_leftover_next, 2'b00});
                    job.value[2] = PAD_CHAR;
                    job.n        = 3'd3;
                end
                job.msg_end       = 1'b1;
                enc_leftover_next = 4'd0;
                enc_phase_next    = 2'd0;
            end
        end
        else
        begin
            if (!dec_stopped_reg && !dec_failed_reg)
            begin
                unique case (info.cls)
                    CLS_STOP:
                    begin
                        dec_stopped_next = 1'b1;
                    end
                    CLS_BAD:
                    begin
                        dec_failed_next = 1'b1;
                        job.value[0]    = in_byte;
                        job.kind[0]     = KIND_ERR;
                        dn              = 3'd1;
                    end
                    CLS_ALPHA:
                    begin
                        if (dec_free_reg > 4'd6 && dec_free_reg <= 4'd8)
                        begin
                            dec_partial_next = dec_partial_reg
                                | 8'({2'b00, info.sextet} << (dec_free_reg - 4'd6));
                            dec_free_next    = dec_free_reg - 4'd6;
                        end
                        else
                        begin
                            fb = (dec_free_reg > 4'd8) ? 4'd8 : dec_free_reg;
                            sh = 4'd6 - fb;
                            nf = fb + 4'd2;
                            job.value[0] = dec_partial_reg
                                | 8'({2'b00, info.sextet} >> sh);
                            dn = 3'd1;
                            if (dec_total_reg < COUNT_LIMIT)
                            begin
                                dec_total_next = dec_total_reg + 16'd1;
                            end
                            dec_partial_next = 8'({2'b00, info.sextet} << nf);
                            dec_free_next    = nf;
                        end
                    end
                    default:
                    begin
                        // newline: drop
                    end
                endcase
            end
            if (in_last)
            begin
                job.value[dn[1:0]] = 8'h00;
                job.kind[dn[1:0]]  = KIND_END;
                job.count          = dec_total_next;
                job.msg_end        = 1'b1;
                dn                 = dn + 3'd1;
                dec_partial_next   = 8'h00;
                dec_free_next      = 4'd8;
                dec_stopped_next   = 1'b0;
                dec_failed_next    = 1'b0;
                dec_total_next     = 16'd0;
            end
            job.n = dn;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_leftover_reg <= 4'd0;
            enc_phase_reg    <= 2'd0;
            dec_partial_reg  <= 8'h00;
            dec_free_reg     <= 4'd8;
            dec_stopped_reg  <= 1'b0;
            dec_failed_reg   <= 1'b0;
            dec_total_reg    <= 16'd0;
        end
        else if (accept)
        begin
            if (direction == DIR_ENCODE)
            begin
                enc_leftover_reg <= enc_leftover_next;
                enc_phase_reg    <= enc_phase_next;
            end
            else
            begin
                dec_partial_reg <= dec_partial_next;
                dec_free_reg    <= dec_free_next;
                dec_stopped_reg <= dec_stopped_next;
                dec_failed_reg  <= dec_failed_next;
                dec_total_reg   <= dec_total_next;
            end
        end
    end

endmodule

@@ src/b64sc_fifo.sv @@
// ---------------------------------------------------------------------------
// b64sc_fifo
// Two-entry job queue between the front and the back.
// ---------------------------------------------------------------------------
module b64sc_fifo
    import b64sc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  job_t         push_job,
    input  logic         pop,
    output job_t         head,
    output fifo_status_t status
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == 2'd2);
    assign status.empty = (cnt_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ src/b64sc_back.sv @@
// ---------------------------------------------------------------------------
// b64sc_back
// Serialises queued jobs into result beats through an output register.
// ---------------------------------------------------------------------------
module b64sc_back
    import b64sc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  job_t         head,
    input  fifo_status_t fifo_status,
    output logic         pop,
    input  logic         out_stall,
    output logic         out_valid,
    output logic [7:0]   out_value,
    output logic [1:0]   out_kind,
    output logic         out_end,
    output logic [15:0]  out_count,
    output logic         out_run_last
);

    job_t        cur_reg, cur_next;
    logic        busy_reg, busy_next;
    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  value_reg;
    kind_t       kind_reg;
    logic        end_reg;
    logic [15:0] count_reg;
    logic        run_last_reg;

    job_t        src;
    logic [1:0]  src_idx;
    logic        src_ok;
    logic        advance;
    logic        done;

    assign src     = busy_reg ? cur_reg : head;
    assign src_idx = busy_reg ? idx_reg : 2'd0;
    assign src_ok  = busy_reg || !fifo_status.empty;
    assign advance = src_ok && (!out_valid_reg || !out_stall);
    assign done    = ({1'b0, src_idx} == (src.n - 3'd1));
    assign pop     = advance && !busy_reg;

    always_comb
    begin
        cur_next       = cur_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (done)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                busy_next = 1'b1;
                cur_next  = src;
                idx_next  = src_idx + 2'd1;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (advance)
        begin
            value_reg    <= src.value[src_idx];
            kind_reg     <= src.kind[src_idx];
            end_reg      <= src.msg_end && done;
            count_reg    <= (src.kind[src_idx] == KIND_END) ? src.count : 16'd0;
            run_last_reg <= done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_value    = value_reg;
    assign out_kind     = kind_reg;
    assign out_end      = end_reg;
    assign out_count    = count_reg;
    assign out_run_last = run_last_reg;

endmodule

@@ src/base64_stream_codec_top.sv @@
// ---------------------------------------------------------------------------
// base64_stream_codec_top
// Streaming Base64 encoder/decoder with a register-selected direction.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one byte or character per beat
//   with in_last on the final beat of a message. Output channel
//   (out_valid/out_stall) carries one result per beat; out_run_last marks the
//   last result caused by an input beat, out_end the last of a message.
//   The direction register (APB, byte address 0, bit 0) selects encode (0)
//   or decode (1); write it only while the codec is idle. pready is tied high.
//   An accepted item's job passes through the job queue, then its results
//   leave one by one through the output register. The front takes one item
//   per cycle while the two-entry job queue has room; the back drains one
//   result per cycle while the receiver does not stall, so encoding sustains
//   about 1.33 results per byte; a padded encode item has up to four results.
//   Items causing no result (newlines, ignored characters) never enter
//   the queue. When the receiver stalls, the output register holds its beat,
//   the queue fills and in_stall rises after two queued jobs.
//   Reset clears encoder and decoder state, the queue and the output valid;
//   direction returns to encode.
// ---------------------------------------------------------------------------
module base64_stream_codec_top
    import b64sc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input channel
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    // output channel
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_value,
    output logic [1:0]        out_kind,
    output logic              out_end,
    output logic [15:0]       out_count,
    output logic              out_run_last
);

    logic         direction_reg, direction_next;
    logic         push;
    logic         pop;
    job_t         job;
    job_t         head;
    fifo_status_t fifo_status;

    // Register file: only the direction bit lives here
    assign pready = 1'b1;

    always_comb
    begin
        direction_next = direction_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION))
        begin
            direction_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ENCODE;
        end
        else
        begin
            direction_reg <= direction_next;
        end
    end

    assign prdata = (paddr[2] == REG_DIRECTION) ? {31'd0, direction_reg} : 32'd0;

    // Front: classify each beat and build its job of result beats
    b64sc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .direction   (direction_reg),
        .in_valid    (in_valid),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .fifo_status (fifo_status),
        .in_stall    (in_stall),
        .push        (push),
        .job         (job)
    );

    // Queue: decouple the front from a stalled output
    b64sc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .head     (head),
        .status   (fifo_status)
    );

    // Back: drain one result beat per cycle, while the receiver does not stall, into the output register
    b64sc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .fifo_status  (fifo_status),
        .pop          (pop),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .out_value    (out_value),
        .out_kind     (out_kind),
        .out_end      (out_end),
        .out_count    (out_count),
        .out_run_last (out_run_last)
    );

    `include "base64_stream_codec_top_assert.svh"

    `B64SC_ASSERT_IMPLIES(a_end_closes_run, out_valid && out_end, out_run_last, "message end not last of its run")
    `B64SC_ASSERT_IMPLIES(a_marker_shape, out_valid && (out_kind == KIND_END), (out_value == 8'h00) && out_end, "malformed end marker")
    `B64SC_ASSERT_IMPLIES(a_count_only_on_marker, out_valid && (out_kind != KIND_END), out_count == 16'd0, "count outside end marker")
    `B64SC_ASSERT_NEXT(a_no_push_when_full, fifo_status.full && !pop, !push || !fifo_status.full, "job queue overrun")

endmodule

@@ sim/b64sc_tb_pkg.sv @@
// ---------------------------------------------------------------------------
// b64sc_tb_pkg
// Result tracking for the Base64 stream codec testbench: a behavioural
// predictor of both directions and an in-order store of awaited result beats.
// ---------------------------------------------------------------------------
package b64sc_tb_pkg;

    import b64sc_pkg::*;

    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // Character classes beyond the 64 alphabet sextets
    localparam int CODE_STOP    = 64;
    localparam int CODE_NEWLINE = 65;
    localparam int CODE_BAD     = 66;

    typedef struct packed {
        logic [7:0]  value;
        kind_t       kind;
        logic        msg_end;
        logic [15:0] count;
        logic        run_last;
    } b64_result_t;

    class b64_result_tracker;
        logic        direction;
        logic [3:0]  enc_leftover;
        logic [1:0]  enc_phase;
        logic [7:0]  dec_partial;
        int unsigned dec_free_bits;
        logic        dec_stopped;
        logic        dec_failed;
        logic [15:0] dec_total;

        b64_result_t awaited[$];
        b64_result_t item_beats[$];

        int unsigned n_items;
        int unsigned n_live;
        int unsigned n_enc;
        int unsigned n_dec;
        int unsigned n_results;
        int unsigned errors;

        function new();
            direction     = DIR_ENCODE;
            enc_leftover  = '0;
            enc_phase     = '0;
            clear_decoder();
            n_items   = 0;
            n_live    = 0;
            n_enc     = 0;
            n_dec     = 0;
            n_results = 0;
            errors    = 0;
        endfunction

        function void clear_decoder();
            dec_partial   = '0;
            dec_free_bits = 8;
            dec_stopped   = 1'b0;
            dec_failed    = 1'b0;
            dec_total     = '0;
        endfunction

        function void set_direction(logic d);
            direction = d;
        endfunction

        function int char_code(logic [7:0] c);
            for (int i = 0; i < 64; i++) begin
                if (B64_ALPHABET[i] == c) return i;
            end
            if (c == PAD_CHAR || c == 8'h00 || c >= 8'h80) return CODE_STOP;
            if (c == NEWLINE_CHAR) return CODE_NEWLINE;
            return CODE_BAD;
        endfunction

        function void add_beat(logic [7:0] v, kind_t k, logic e, logic [15:0] cnt);
            b64_result_t r;
            r.value    = v;
            r.kind     = k;
            r.msg_end  = e;
            r.count    = cnt;
            r.run_last = 1'b0;
            item_beats.push_back(r);
        endfunction

        function void add_char(logic [5:0] s);
            add_beat(B64_ALPHABET[int'(s)], KIND_DATA, 1'b0, '0);
        endfunction

        function void encode_byte(logic [7:0] b, logic last);
            case (enc_phase)
                2'd0: begin
                    add_char(b[7:2]);
                    enc_leftover = {2'b00, b[1:0]};
                    enc_phase    = 2'd1;
                end
                2'd1: begin
                    add_char({enc_leftover[1:0], b[7:4]});
                    enc_leftover = b[3:0];
                    enc_phase    = 2'd2;
                end
                default: begin
                    add_char({enc_leftover, b[7:6]});
                    add_char(b[5:0]);
                    enc_leftover = '0;
                    enc_phase    = 2'd0;
                end
            endcase
            if (last) begin
                // flush the leftover bits and pad to a whole quartet
                if (enc_phase == 2'd1) begin
                    add_char({enc_leftover[1:0], 4'b0000});
                    add_beat(PAD_CHAR, KIND_DATA, 1'b0, '0);
                    add_beat(PAD_CHAR, KIND_DATA, 1'b0, '0);
                end else if (enc_phase == 2'd2) begin
                    add_char({enc_leftover, 2'b00});
                    add_beat(PAD_CHAR, KIND_DATA, 1'b0, '0);
                end
                item_beats[item_beats.size() - 1].msg_end = 1'b1;
                enc_leftover = '0;
                enc_phase    = '0;
            end
        endfunction

        function void decode_char(logic [7:0] c, logic last);
            int unsigned code;
            code = char_code(c);
            if (!dec_stopped && !dec_failed) begin
                if (code == CODE_STOP) begin
                    dec_stopped = 1'b1;
                end else if (code == CODE_BAD) begin
                    dec_failed = 1'b1;
                    add_beat(c, KIND_ERR, 1'b0, '0);
                end else if (code < 64) begin
                    if (dec_free_bits == 8) begin
                        dec_partial   = 8'(code << 2);
                        dec_free_bits = 2;
                    end else begin
                        add_beat(dec_partial | 8'(code >> (6 - dec_free_bits)),
                                 KIND_DATA, 1'b0, '0);
                        if (dec_total < COUNT_LIMIT) dec_total++;
                        dec_free_bits += 2;
                        dec_partial = 8'(code << dec_free_bits);
                    end
                end
            end
            if (last) begin
                add_beat(8'h00, KIND_END, 1'b1, dec_total);
                clear_decoder();
            end
        endfunction

        // Work out the result beats of one accepted input beat
        function void note_item(logic [7:0] b, logic last);
            item_beats.delete();
            n_items++;
            if (direction == DIR_ENCODE) begin
                n_enc++;
                n_live++;
                encode_byte(b, last);
            end else begin
                n_dec++;
                if (last || (!dec_stopped && !dec_failed && char_code(b) != CODE_NEWLINE))
                    n_live++;
                decode_char(b, last);
            end
            if (item_beats.size() > 0)
                item_beats[item_beats.size() - 1].run_last = 1'b1;
            foreach (item_beats[i]) awaited.push_back(item_beats[i]);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t ns, result beat %0d: %s", $time, n_results, what);
            errors++;
        endtask

        task check_beat(logic [7:0] value, logic [1:0] kind, logic msg_end,
                        logic [15:0] count, logic run_last);
            b64_result_t want;
            n_results++;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("unexpected beat value %02h kind %0d",
                                          value, kind));
                return;
            end
            want = awaited.pop_front();
            if (value !== want.value)
                report_mismatch($sformatf("value %02h, want %02h", value, want.value));
            if (kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
            if (msg_end !== want.msg_end)
                report_mismatch($sformatf("end flag %0b, want %0b", msg_end, want.msg_end));
            if (count !== want.count)
                report_mismatch($sformatf("count %0d, want %0d", count, want.count));
            if (run_last !== want.run_last)
                report_mismatch($sformatf("run-last flag %0b, want %0b",
                                          run_last, want.run_last));
        endtask
    endclass

endpackage

@@ sim/base64_stream_codec_top_tb.sv @@
// ---------------------------------------------------------------------------
// base64_stream_codec_top_tb
// Self-checking bench for the Base64 stream codec in both directions.
// Drives byte and character beats with bursty gaps against a stalling
// receiver, predicts every result beat and compares them in order; covers
// padding, newlines, stop and invalid characters, state kept across
// direction changes, a back-pressure hold-off and back-to-back streaming.
// ---------------------------------------------------------------------------
module base64_stream_codec_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64sc_pkg::*;
    import b64sc_tb_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int HOLD_CYCLES     = 80;    // long receiver hold-off
    localparam int DRAIN_CYCLES    = 8;     // room for items still in the front
    localparam int IDLE_LIMIT      = 2000;  // cycles without any beat moving
    localparam int PHASE_ITEMS     = 65;    // least number of live items per random phase

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        in_byte;
    logic              in_last;
    logic              out_valid;
    logic              out_stall;
    logic [7:0]        out_value;
    logic [1:0]        out_kind;
    logic              out_end;
    logic [15:0]       out_count;
    logic              out_run_last;

    b64_result_tracker tracker = new();

    logic [7:0]  msg_bytes[$];
    int unsigned burst_left = 0;
    bit          no_gaps    = 1'b0;   // sender offers back to back
    bit          quiet_rx   = 1'b0;   // receiver never stalls
    bit          hold_req   = 1'b0;   // ask the receiver for a long hold-off

    base64_stream_codec_top uut (.*);

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Sender side
    // -----------------------------------------------------------------------

    // Offer one beat and hold it until accepted. Enters and leaves on a
    // falling edge; valid stays high between beats of a burst.
    task automatic send_item(logic [7:0] b, logic last);
        int unsigned gap;
        if (!no_gaps) begin
            if (burst_left == 0) begin
                // drop valid for a random gap, then start a fresh burst
                gap = $urandom_range(1, 8);
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 8);
            end
            burst_left--;
        end
        in_valid = 1'b1;
        in_byte  = b;
        in_last  = last;
        do @(posedge clk); while (in_stall);
        tracker.note_item(b, last);
        @(negedge clk);
    endtask

    task automatic send_message();
        foreach (msg_bytes[i]) send_item(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], i == s.len() - 1);
    endtask

    // Wait until every awaited beat is in, then give items that cause no
    // result time to leave the front before the register is touched.
    task automatic wait_drained();
        in_valid = 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands on the edge with pready
    task automatic write_direction(logic d);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_W'(4 * REG_DIRECTION);
        pwdata  = {31'd0, d};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        tracker.set_direction(d);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [7:0] random_alpha();
        return B64_ALPHABET[$urandom_range(0, 63)];
    endfunction

    function automatic logic [7:0] random_invalid();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 127)); while (tracker.char_code(c) != CODE_BAD);
        return c;
    endfunction

    task automatic gen_encode_message();
        int unsigned len;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
        msg_bytes.delete();
        repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
        send_message();
    endtask

    // Mostly well-formed text with random content; the rest carries errors,
    // early stops, truncated quartets or plain noise.
    task automatic gen_decode_message();
        int unsigned shape;
        int unsigned quartets;
        int unsigned pad;
        int unsigned pos;
        shape    = $urandom_range(0, 9);
        quartets = $urandom_range(1, 5);
        msg_bytes.delete();
        for (int i = 0; i < quartets * 4; i++) begin
            msg_bytes.push_back(random_alpha());
            if ($urandom_range(0, 15) == 0) msg_bytes.push_back(NEWLINE_CHAR);
        end
        pos = $urandom_range(0, msg_bytes.size() - 1);
        case (shape)
            0, 1, 2, 3, 4, 5: begin
                pad = $urandom_range(0, 2);
                repeat (pad) void'(msg_bytes.pop_back());
                repeat (pad) msg_bytes.push_back(PAD_CHAR);
                if ($urandom_range(0, 3) == 0) msg_bytes.push_back(NEWLINE_CHAR);
            end
            6: msg_bytes.insert(pos, random_invalid());
            7: msg_bytes.insert(pos, ($urandom_range(0, 1) == 0)
                                     ? 8'h00 : 8'($urandom_range(128, 255)));
            8: begin
                // up to seven characters: partial bits are dropped at the end
                msg_bytes.delete();
                repeat ($urandom_range(1, 7)) msg_bytes.push_back(random_alpha());
            end
            default: begin
                msg_bytes.delete();
                repeat ($urandom_range(1, 8)) msg_bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
        send_message();
    endtask

    task automatic run_random(logic d, int unsigned target);
        int unsigned start;
        start = tracker.n_live;
        while (tracker.n_live - start < target) begin
            if (d == DIR_ENCODE) gen_encode_message();
            else gen_decode_message();
        end
        wait_drained();
    endtask

    // -----------------------------------------------------------------------
    // Receiver side: stall runs of its own, a quiet mode and a long hold-off
    // -----------------------------------------------------------------------
    initial begin
        int unsigned stall_left;
        int unsigned free_left;
        logic        next_stall;
        stall_left = 0;
        free_left  = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                // hold off long enough for the queue to fill and stall the input
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
                hold_req  = 1'b0;
            end else begin
                if (quiet_rx) begin
                    next_stall = 1'b0;
                end else if (free_left > 0) begin
                    next_stall = 1'b0;
                    free_left--;
                end else if (stall_left > 0) begin
                    next_stall = 1'b1;
                    stall_left--;
                end else begin
                    stall_left = $urandom_range(1, 6);
                    free_left  = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 12);
                    next_stall = 1'b1;
                end
                out_stall = next_stall;
            end
        end
    end

    // Sample result beats at the rising edge and check them in order
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_beat(out_value, out_kind, out_end, out_count, out_run_last);
    end

    // Watchdog: end the run when no beat has moved for too long
    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Timed out with %0d result beats still awaited", tracker.pending());
        $display("Mismatches found");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        in_byte  = '0;
        in_last  = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed encode: two pads, one pad, no pad, then leave a message open
        write_direction(DIR_ENCODE);
        msg_bytes = '{8'h00};
        send_message();
        msg_bytes = '{8'hFF, 8'h80};
        send_message();
        msg_bytes = '{8'h4D, 8'h61, 8'h6E};
        send_message();
        send_item(8'h01, 1'b0);
        wait_drained();

        // Directed decode: alphabet extremes with a newline as the last beat,
        // stop on pad, invalid character, stop on a high code and on NUL
        write_direction(DIR_DECODE);
        send_text("/+az\n");
        send_text("Zg=");
        send_text("A*B");
        msg_bytes = '{8'h80, 8'h41};
        send_message();
        msg_bytes = '{8'h00};
        send_message();
        wait_drained();

        // Back to encode: the open message must resume where it stopped
        write_direction(DIR_ENCODE);
        msg_bytes = '{8'h02, 8'h03};
        send_message();
        wait_drained();

        // Random phases
        run_random(DIR_ENCODE, PHASE_ITEMS);
        write_direction(DIR_DECODE);
        run_random(DIR_DECODE, PHASE_ITEMS);

        // Hold the receiver off while the sender keeps offering beats
        write_direction(DIR_ENCODE);
        hold_req = 1'b1;
        run_random(DIR_ENCODE, PHASE_ITEMS);

        // Back-to-back decode against a receiver that never stalls
        write_direction(DIR_DECODE);
        no_gaps  = 1'b1;
        quiet_rx = 1'b1;
        run_random(DIR_DECODE, PHASE_ITEMS);
        no_gaps  = 1'b0;
        quiet_rx = 1'b0;

        $display("Run covered %0d input beats (%0d encode, %0d decode) and %0d result beats,",
                 tracker.n_items, tracker.n_enc, tracker.n_dec, tracker.n_results);
        $display("with padding, stops, invalid characters, hold-off and gapless streaming.");
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/b64sc_pkg.sv
src/b64sc_front.sv
src/b64sc_fifo.sv
src/b64sc_back.sv
src/base64_stream_codec_top.sv
sim/b64sc_tb_pkg.sv
sim/base64_stream_codec_top_tb.sv
